// ===== rtl/fpdr_pkg.sv =====
// fpdr_pkg: widths, constants and the cell payload type for the rounded
// 20.12 fixed-point divider. No dependencies.
`timescale 1ns / 1ps

package fpdr_pkg;

	localparam int DATA_W     = 32;
	localparam int QUO_W      = 52;
	localparam int FRAC_SHIFT = 20;
	localparam int NUM_STEPS  = 64;
	localparam int LATENCY    = NUM_STEPS + 3;

	localparam logic [QUO_W-1:0] ROUND_ADD = QUO_W'(20'h80000);

	typedef struct packed {
		logic              neg;
		logic              dz;
		logic [DATA_W-1:0] rem;
		logic [DATA_W-1:0] dvd;
		logic [DATA_W-1:0] den;
		logic [QUO_W-1:0]  quo;
	} fpdr_data_t;

endpackage

// ===== rtl/fpdr_cell.sv =====
// fpdr_cell: one restoring-division step of the divider chain, registered.
// Depends on fpdr_pkg.
`timescale 1ns / 1ps

module fpdr_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld_in,
	input  fpdr_pkg::fpdr_data_t d_in,
	output logic               vld_out,
	output fpdr_pkg::fpdr_data_t d_out
);
	import fpdr_pkg::*;

	logic [DATA_W:0]   trial;
	logic [DATA_W+1:0] diff;
	logic              ge;
	fpdr_data_t        nxt;
	logic              vld_s1;
	fpdr_data_t        data_s1;

	always_comb begin
		trial = {d_in.rem, d_in.dvd[DATA_W-1]};
		diff  = {1'b0, trial} - {2'b00, d_in.den};
		ge    = ~diff[DATA_W+1];
		nxt     = d_in;
		nxt.rem = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
		nxt.dvd = {d_in.dvd[DATA_W-2:0], 1'b0};
		nxt.quo = {d_in.quo[QUO_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= nxt;
	end

	assign vld_out = vld_s1;
	assign d_out   = data_s1;

endmodule

// ===== rtl/fpdr_round.sv =====
// fpdr_round: applies the quotient sign, rounds to 20.12 and forces the
// zero-divisor result. Two registered stages. Depends on fpdr_pkg.
`timescale 1ns / 1ps

module fpdr_round (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        vld_in,
	input  fpdr_pkg::fpdr_data_t        d_in,
	output logic                        done,
	output logic [fpdr_pkg::DATA_W-1:0] quotient_fixed
);
	import fpdr_pkg::*;

	logic              vld_s1;
	logic              dz_s1;
	logic [QUO_W-1:0]  val_s1;
	logic              vld_s2;
	logic [DATA_W-1:0] res_s2;
	logic [QUO_W-1:0]  sum;

	assign sum = val_s1 + ROUND_ADD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		dz_s1  <= d_in.dz;
		val_s1 <= d_in.neg ? (~d_in.quo + QUO_W'(1)) : d_in.quo;
		res_s2 <= dz_s1 ? '0 : sum[QUO_W-1:FRAC_SHIFT];
	end

	assign done           = vld_s2;
	assign quotient_fixed = res_s2;

endmodule

// ===== rtl/fixed_point_divide_round_20_12_top.sv =====
// fixed_point_divide_round_20_12_top: pipelined signed divider giving a
// rounded 20.12 quotient. Depends on fpdr_pkg, fpdr_cell and fpdr_round.
`timescale 1ns / 1ps

// Usage:
//   Drive numerator and divisor and raise start; the pair transfers at the
//   clock edge where start is high and busy is low. busy is high only
//   during reset and for the first cycle after it; after that every cycle
//   takes a new pair.
//   Each pair gives one result: done is high for exactly one cycle with
//   quotient_fixed = low 32 bits of round((numerator * 2^32) / divisor,
//   20 fraction bits), the division truncated toward zero.
//   A zero divisor gives 0.
//   Pipeline: one operand stage, 64 division cells (one quotient bit each),
//   one sign stage and one rounding stage; done is the registered valid of
//   the rounding stage.
//   Throughput: one pair per cycle; the cell chain advances every cycle.
//   Results come out in transfer order. The receiver cannot stall; a result
//   not taken in its done cycle is gone.
//   Reset clears every valid flag in the chain; items in flight are lost.

module fixed_point_divide_round_20_12_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [fpdr_pkg::DATA_W-1:0] numerator,
	input  logic [fpdr_pkg::DATA_W-1:0] divisor,
	output logic                        done,
	output logic [fpdr_pkg::DATA_W-1:0] quotient_fixed
);
	import fpdr_pkg::*;

	logic       busy_q;
	logic       accept;
	logic       vld_s0;
	fpdr_data_t data_s0;
	logic       chain_vld [NUM_STEPS+1];
	fpdr_data_t chain_dat [NUM_STEPS+1];

	assign accept = start & ~busy_q;
	assign busy   = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			vld_s0 <= 1'b0;
		end else begin
			busy_q <= 1'b0;
			vld_s0 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		data_s0.neg <= numerator[DATA_W-1] ^ divisor[DATA_W-1];
		data_s0.dz  <= (divisor == '0);
		data_s0.rem <= '0;
		data_s0.dvd <= numerator[DATA_W-1] ? (~numerator + DATA_W'(1)) : numerator;
		data_s0.den <= divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;
		data_s0.quo <= '0;
	end

	assign chain_vld[0] = vld_s0;
	assign chain_dat[0] = data_s0;

	for (genvar i = 0; i < NUM_STEPS; i++) begin : g_cell
		fpdr_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (chain_vld[i]),
			.d_in    (chain_dat[i]),
			.vld_out (chain_vld[i+1]),
			.d_out   (chain_dat[i+1])
		);
	end

	fpdr_round u_round (
		.clk            (clk),
		.arst_n         (arst_n),
		.vld_in         (chain_vld[NUM_STEPS]),
		.d_in           (chain_dat[NUM_STEPS]),
		.done           (done),
		.quotient_fixed (quotient_fixed)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result strobe missing after transfer");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without matching transfer");

	a_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && divisor == '0) |-> ##LATENCY (quotient_fixed == '0))
		else $error("zero divisor gave non-zero result");

endmodule

// ===== sim/tb.sv =====
// tb: self-checking testbench for fixed_point_divide_round_20_12_top, a pipelined
// divider with a rounded 20.12 result. It predicts each quotient, checks every result
// in order, and uses fpdr_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module tb;

	import fpdr_pkg::*;

	localparam int                        RESET_CYCLES = 8;
	localparam int                        CYCLE_LIMIT  = 500000;
	localparam int                        RANDOM_ITEMS = 2000;
	localparam logic signed [DATA_W-1:0]  MOST_NEG     = 32'sh80000000;
	localparam logic signed [DATA_W-1:0]  MOST_POS     = 32'sh7fffffff;
	localparam logic        [63:0]        ROUND_BIAS   = 64'h80000;

	typedef struct {
		logic [DATA_W-1:0] num;
		logic [DATA_W-1:0] den;
		logic [DATA_W-1:0] quo;
	} division_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [DATA_W-1:0] numerator = '0;
	logic [DATA_W-1:0] divisor = '0;
	logic              done;
	logic [DATA_W-1:0] quotient_fixed;

	division_t pending_quotients[$];
	int        mismatches = 0;
	int        pairs_sent = 0;
	int        results_checked = 0;
	int        zero_divisors = 0;
	int        cycles = 0;
	bit        idle_allowed = 1'b1;

	fixed_point_divide_round_20_12_top uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.numerator      (numerator),
		.divisor        (divisor),
		.done           (done),
		.quotient_fixed (quotient_fixed)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_quotients.size());
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [DATA_W-1:0] rounded_quotient(input logic signed [DATA_W-1:0] num,
		input logic signed [DATA_W-1:0] den);
		logic signed [63:0] scaled;
		logic signed [63:0] den_wide;
		logic signed [63:0] quot;
		logic        [63:0] rounded;
		scaled   = {num, 32'h0};
		den_wide = den;
		if (den == 0) begin
			quot = (scaled < 0) ? 64'sd1 : -64'sd1;
		end else if (den == -1 && num == MOST_NEG) begin
			// divider overflow: quotient stays at -2^63
			quot = scaled;
		end else begin
			quot = scaled / den_wide;
		end
		rounded = quot + ROUND_BIAS;
		return rounded[FRAC_SHIFT +: DATA_W];
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_allowed || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [DATA_W-1:0] small_signed(input int unsigned span);
		logic [DATA_W-1:0] v;
		v = $urandom_range(0, span);
		if ($urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	// one transfer; start stays high so back-to-back pairs need no gap
	task automatic send_pair(input logic [DATA_W-1:0] num, input logic [DATA_W-1:0] den);
		division_t d;
		int        gap;
		gap = gap_cycles();
		if (gap > 0) begin
			@(negedge clk);
			start     = 1'b0;
			numerator = $urandom;
			divisor   = $urandom;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start     = 1'b1;
		numerator = num;
		divisor   = den;
		do
			@(posedge clk);
		while (busy);
		d.num = num;
		d.den = den;
		d.quo = rounded_quotient(num, den);
		pending_quotients.push_back(d);
		pairs_sent++;
		if (den == 0)
			zero_divisors++;
	endtask

	task automatic stop_sending();
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_quotients.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		division_t d;
		if (arst_n && done) begin
			if (pending_quotients.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", quotient_fixed));
			end else begin
				d = pending_quotients.pop_front();
				results_checked++;
				if (quotient_fixed !== d.quo)
					report_mismatch($sformatf("%h / %h: quotient_fixed %h, want %h",
						d.num, d.den, quotient_fixed, d.quo));
			end
		end
	end

	task automatic test_extremes();
		send_pair(MOST_POS, MOST_POS);
		send_pair(MOST_NEG, MOST_NEG);
		send_pair(MOST_POS, MOST_NEG);
		send_pair(MOST_NEG, MOST_POS);
		send_pair(MOST_POS, 32'sd1);
		send_pair(MOST_NEG, 32'sd1);
		send_pair(MOST_POS, -32'sd1);
		send_pair(32'sd0, MOST_POS);
		send_pair(32'sd0, MOST_NEG);
		send_pair(32'sd1, MOST_POS);
		send_pair(-32'sd1, MOST_NEG);
		send_pair(32'sd1, 32'sd1);
		send_pair(-32'sd1, 32'sd1);
	endtask

	task automatic test_special_cases();
		// zero divisor, with every sign of numerator
		send_pair(32'sd0, 32'sd0);
		send_pair(32'sd5, 32'sd0);
		send_pair(-32'sd5, 32'sd0);
		send_pair(MOST_NEG, 32'sd0);
		send_pair(MOST_POS, 32'sd0);
		// overflowing divide
		send_pair(MOST_NEG, -32'sd1);
		// rounding at and on either side of one half
		send_pair(32'sd1, 32'sd8192);
		send_pair(32'sd1, 32'sd8193);
		send_pair(-32'sd1, 32'sd8192);
		send_pair(-32'sd1, 32'sd8191);
		send_pair(32'sd3, -32'sd8192);
	endtask

	task automatic test_random_pairs();
		logic [DATA_W-1:0] num;
		logic [DATA_W-1:0] den;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 200 == 0)
				idle_allowed = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					num = $urandom;
					den = $urandom;
				end
				4: begin
					num = $urandom;
					den = small_signed(4095);
				end
				5: begin
					num = small_signed(65535);
					den = $urandom;
				end
				6: begin
					num = $urandom;
					case ($urandom_range(0, 2))
						0: den = 32'sd0;
						1: den = 32'sd1;
						default: den = -32'sd1;
					endcase
				end
				7: begin
					num = $urandom_range(0, 1) ? MOST_NEG : MOST_POS;
					den = $urandom_range(0, 3) == 0 ? -32'sd1 : $urandom;
				end
				8: begin
					num = $urandom;
					den = $signed(num) >>> $urandom_range(0, 24);
				end
				default: begin
					num = small_signed(32767);
					den = small_signed(32767);
				end
			endcase
			send_pair(num, den);
		end
		idle_allowed = 1'b1;
	endtask

	task automatic test_drain_pause();
		for (int burst = 0; burst < 3; burst++) begin
			for (int i = 0; i < 10; i++)
				send_pair($urandom, small_signed(1 << (8 * burst + 4)));
			stop_sending();
			wait_drained();
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_extremes();
		test_special_cases();
		test_drain_pause();
		test_random_pairs();
		stop_sending();

		wait_drained();
		repeat (LATENCY + 8) @(posedge clk);

		$display("%0d operand pairs sent (%0d with zero divisor), %0d results checked",
			pairs_sent, zero_divisors, results_checked);
		$display("covered extremes, zero and overflowing divides, rounding ties, idle gaps");
		if (mismatches == 0 && pending_quotients.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== fixed_point_divide_round_20_12_top.f =====
rtl/fpdr_pkg.sv
rtl/fpdr_cell.sv
rtl/fpdr_round.sv
rtl/fixed_point_divide_round_20_12_top.sv
sim/tb.sv
